/* sv/isa_pkg.sv */
`timescale 1ns / 1ps

package isa_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] REG_DESCENDING = 2'd0;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflowed;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
  } elem_t;

  typedef struct packed {
    logic shift;
    logic descending;
  } cell_ctl_t;

  // true when a belongs ahead of b in the chosen order
  function automatic logic precedes(logic signed [31:0] a, logic signed [31:0] b,
                                    logic desc);
    return desc ? (a > b) : (a < b);
  endfunction

endpackage

/* sv/integer_array_sorter.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Word
// in       input      in_valid / in_stall  in_word  (value, last_in)
// out      output     out_valid/ out_stall out_word (sorted_value, last_out, overflowed)
// cfg      input      APB psel/penable     descending at byte address 0
//
// Loading takes one element per cycle; each element ripples one cell per cycle.
// After the closing element the chain settles in the SETTLE state, then emits one
// result per cycle while out_stall is low, from the head cell while the chain shifts toward it.
// in_stall is high from the closing element until the final result is taken.
// Reset is synchronous and clears all control state and the descending register.
module integer_array_sorter #(
  parameter int DEPTH = isa_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  isa_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output isa_pkg::out_word_t          out_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [isa_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import isa_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {LOAD, SETTLE, EMIT} state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] settle;
  logic          dropped;
  logic          descending;

  logic          in_acc;
  logic          out_acc;
  logic          room;
  cell_ctl_t     ctl;
  elem_t         stored [DEPTH];
  elem_t         pass   [DEPTH];
  elem_t         left   [DEPTH];
  elem_t         right  [DEPTH];

  assign pready = 1'b1;
  assign prdata = (paddr == REG_DESCENDING) ? {31'd0, descending} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_DESCENDING) begin
      descending <= pwdata[0];
    end
  end

  assign in_stall  = (state != LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state == EMIT);
  assign out_acc   = out_valid && !out_stall;
  assign room      = (count < CW'(DEPTH));

  assign ctl.shift      = out_acc;
  assign ctl.descending = descending;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      left[i]  = (i == 0) ? elem_t'{valid: in_acc && room, value: in_word.value}
                          : pass[(i == 0) ? 0 : i - 1];
      right[i] = (i == DEPTH - 1) ? elem_t'{valid: 1'b0, value: 32'sd0}
                                  : stored[(i == DEPTH - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    isa_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .left_in      (left[g]),
      .right_stored (right[g]),
      .stored       (stored[g]),
      .pass_out     (pass[g])
    );
  end

  assign out_word.sorted_value = stored[0].value;
  assign out_word.last_out     = (count == CW'(1));
  assign out_word.overflowed   = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= LOAD;
      count   <= '0;
      settle  <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (in_acc) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (in_word.last_in) begin
              state  <= SETTLE;
              settle <= CW'(DEPTH);
            end
          end
        end
        SETTLE: begin
          if (settle == '0) begin
            state <= EMIT;
          end else begin
            settle <= settle - CW'(1);
          end
        end
        EMIT: begin
          if (out_acc) begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              state   <= LOAD;
              dropped <= 1'b0;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count exceeds depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0 && stored[0].valid))
    else $error("result offered from an empty chain");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (out_acc && out_word.last_out) |=> (count == '0 && !dropped && !in_stall))
    else $error("run not cleared after final result");

  a_close_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_word.last_in) |=> (in_stall && !out_valid))
    else $error("input not held after run close");

endmodule

/* sv/isa_cell.sv */
`timescale 1ns / 1ps

module isa_cell (
  input  logic              clk,
  input  logic              rst,
  input  isa_pkg::cell_ctl_t ctl,
  input  isa_pkg::elem_t    left_in,
  input  isa_pkg::elem_t    right_stored,
  output isa_pkg::elem_t    stored,
  output isa_pkg::elem_t    pass_out
);
  import isa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored.valid   <= 1'b0;
      pass_out.valid <= 1'b0;
    end else if (ctl.shift) begin
      stored         <= right_stored;
      pass_out.valid <= 1'b0;
    end else if (left_in.valid) begin
      if (!stored.valid) begin
        stored         <= left_in;
        pass_out.valid <= 1'b0;
      end else if (precedes(left_in.value, stored.value, ctl.descending)) begin
        // keep the newcomer, push the old holder right
        stored   <= left_in;
        pass_out <= stored;
      end else begin
        pass_out <= left_in;
      end
    end else begin
      pass_out.valid <= 1'b0;
    end
  end

endmodule
